// File: design/itoa_pkg.sv
// Shared types and constants for the int32 to decimal ASCII converter.
// Used by itoa_bcd_conv and int32_to_decimal_ascii_core; no dependencies.
package itoa_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned STEP_W     = $clog2(DATA_W);
  localparam int unsigned NDIG_W     = $clog2(BCD_DIGITS + 1);
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Status of the binary to BCD unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

// File: design/itoa_bcd_conv.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on itoa_pkg.
module itoa_bcd_conv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [itoa_pkg::DATA_W-1:0]  mag_i,
  output logic [itoa_pkg::BCD_W-1:0]   bcd_o,
  output itoa_pkg::conv_stat_t         stat_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [itoa_pkg::STEP_W-1:0]   step_q;
  logic [itoa_pkg::DATA_W-1:0]   bin_q;
  logic [itoa_pkg::DATA_W-1:0]   bin_d;
  logic [itoa_pkg::BCD_W-1:0]    bcd_q;
  logic [itoa_pkg::BCD_W-1:0]    bcd_d;
  logic [itoa_pkg::BCD_W-1:0]    adj;

  // Each digit of five or more is corrected by three before the shift.
  always_comb begin
    for (int i = 0; i < int'(itoa_pkg::BCD_DIGITS); i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
    {bcd_d, bin_d} = {adj[itoa_pkg::BCD_W-2:0], bin_q, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + itoa_pkg::STEP_W'(1);
        if (step_q == itoa_pkg::STEP_W'(itoa_pkg::DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= mag_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign bcd_o       = bcd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: design/int32_to_decimal_ascii_core.sv
// A new value is accepted only in the idle state, so the next item waits until the last
// character of the current run has entered the output register; the 32-step
// shift-and-add-3 loop in itoa_bcd_conv takes most of the time of a run.
// Characters leave at one per cycle while the output side is ready.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the
// output register; any run in progress is dropped.
module int32_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value (signed)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] character
  output logic        m_axis_tlast_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_STRIP = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam int unsigned TOP_NIB = itoa_pkg::BCD_W - 4;

  logic [2:0]                       state_q;
  logic                             neg_q;
  logic [itoa_pkg::BCD_W-1:0]       dig_q;
  logic [itoa_pkg::NDIG_W-1:0]      ndig_q;
  logic                             out_valid_q;
  logic [itoa_pkg::CHAR_W-1:0]      out_char_q;
  logic                             out_last_q;

  logic                             in_xfer;
  logic                             slot_free;
  logic                             out_load;
  logic [itoa_pkg::DATA_W-1:0]      mag;
  logic [itoa_pkg::BCD_W-1:0]       bcd;
  itoa_pkg::conv_stat_t             conv_stat;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // The output register can take a new character when it is empty or its
  // current character is being transferred in this cycle.
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // A new character enters the output register in this cycle.
  assign out_load = slot_free && (state_q inside {S_SIGN, S_EMIT});

  // Magnitude in unsigned arithmetic, so the most negative value needs no
  // special handling: its negation is 2^31 itself.
  assign mag = s_axis_tdata_i[31] ? (32'd0 - s_axis_tdata_i) : s_axis_tdata_i;

  itoa_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .mag_i   (mag),
    .bcd_o   (bcd),
    .stat_o  (conv_stat)
  );

  // Control: after conversion the leading zero digits are stripped one per
  // cycle (keeping at least one digit, so zero yields a single '0'), then the
  // sign goes out for negative values, then the digits most significant first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            state_q <= S_STRIP;
          end
        end
        S_STRIP: begin
          if (!(ndig_q > itoa_pkg::NDIG_W'(1) && dig_q[TOP_NIB +: 4] == 4'd0)) begin
            state_q <= neg_q ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free && ndig_q == itoa_pkg::NDIG_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: sign flag, digit shift register, digit count and output character.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      neg_q <= s_axis_tdata_i[31];
    end
    case (state_q)
      S_CONV: begin
        if (conv_stat.done) begin
          dig_q  <= bcd;
          ndig_q <= itoa_pkg::NDIG_W'(itoa_pkg::BCD_DIGITS);
        end
      end
      S_STRIP: begin
        if (ndig_q > itoa_pkg::NDIG_W'(1) && dig_q[TOP_NIB +: 4] == 4'd0) begin
          dig_q  <= {dig_q[TOP_NIB-1:0], 4'd0};
          ndig_q <= ndig_q - itoa_pkg::NDIG_W'(1);
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_char_q <= itoa_pkg::ASCII_MINUS;
          out_last_q <= 1'b0;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_char_q <= itoa_pkg::ASCII_ZERO + {4'd0, dig_q[TOP_NIB +: 4]};
          out_last_q <= (ndig_q == itoa_pkg::NDIG_W'(1));
          dig_q      <= {dig_q[TOP_NIB-1:0], 4'd0};
          ndig_q     <= ndig_q - itoa_pkg::NDIG_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  // An accepted item always starts the conversion loop.
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_CONV && conv_stat.busy))
    else $error("conversion did not start after input transfer");

  // The conversion unit is never busy while the sequencer is idle.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !conv_stat.busy)
    else $error("conversion unit busy while idle");

  // Every character is a digit, or a minus sign that never ends a run.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o >= itoa_pkg::ASCII_ZERO &&
                          m_axis_tdata_o <= itoa_pkg::ASCII_ZERO + 8'd9) ||
                         (m_axis_tdata_o == itoa_pkg::ASCII_MINUS && !m_axis_tlast_o)))
    else $error("illegal output character");

  // Digits are emitted only while at least one remains.
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (ndig_q != '0))
    else $error("emit with no digits left");
`endif

endmodule
